// ===== hdl/rvi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RV32I I-type execute core.
package rvi_pkg;

  localparam int XLEN    = 32;
  localparam int REG_W   = 5;
  localparam int ACT_W   = 5;
  localparam int IMM_W   = 12;
  localparam int PWORD_W = 10;

  // Action codes carried by a request
  typedef enum logic [ACT_W-1:0] {
    ACT_LB      = 5'd0,
    ACT_LH      = 5'd1,
    ACT_LW      = 5'd2,
    ACT_LBU     = 5'd3,
    ACT_LHU     = 5'd4,
    ACT_ADDI    = 5'd5,
    ACT_SLLI    = 5'd6,
    ACT_SLTI    = 5'd7,
    ACT_SLTIU   = 5'd8,
    ACT_XORI    = 5'd9,
    ACT_ORI     = 5'd10,
    ACT_ANDI    = 5'd11,
    ACT_SRLI    = 5'd12,
    ACT_SRAI    = 5'd13,
    ACT_JALR    = 5'd14,
    ACT_PRE_REG = 5'd15,
    ACT_PRE_MEM = 5'd16
  } act_t;

  // Per-request control and data carried down the pipe
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [REG_W-1:0] rd;
    logic             wen;      // writes a nonzero register
    logic             is_load;
    logic             is_pmem;  // memory preload; val holds the store data
    logic [1:0]       off;      // byte offset of the load address
    logic [XLEN-1:0]  val;
    logic             jump;
    logic [XLEN-1:0]  npc;
  } ex_ctl_t;

  // Load enables for the word index reduction stages
  typedef struct packed {
    logic ld_s2;
    logic ld_s3;
  } red_adv_t;

endpackage

// ===== hdl/rvi_chan_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces of the execute core.
interface rvi_in_if import rvi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [REG_W-1:0]   dest_reg;
  logic [REG_W-1:0]   src_reg;
  logic [IMM_W-1:0]   immediate_bits;
  logic [XLEN-1:0]    current_pc;
  logic [XLEN-1:0]    preload_value;
  logic [PWORD_W-1:0] preload_word;

  modport source (
    output valid, action, dest_reg, src_reg, immediate_bits, current_pc,
           preload_value, preload_word,
    input  ready
  );
  modport sink (
    input  valid, action, dest_reg, src_reg, immediate_bits, current_pc,
           preload_value, preload_word,
    output ready
  );
endinterface

interface rvi_out_if import rvi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             write_enable;
  logic [REG_W-1:0] written_reg;
  logic [XLEN-1:0]  written_value;
  logic             jump_taken;
  logic [XLEN-1:0]  next_pc;

  modport source (
    output valid, write_enable, written_reg, written_value, jump_taken, next_pc,
    input  ready
  );
  modport sink (
    input  valid, write_enable, written_reg, written_value, jump_taken, next_pc,
    output ready
  );
endinterface

// ===== hdl/rv32i_itype_execute_core.sv =====
`timescale 1ns / 1ps
// Top level of the RV32I I-type execute core: register file, data memory, pipeline.
//
//  channel   dir  handshake           payload
//  in_req    in   valid / ready       action, dest_reg, src_reg, immediate_bits,
//                                     current_pc, preload_value, preload_word
//  out_rsp   out  valid / ready       write_enable, written_reg, written_value,
//                                     jump_taken, next_pc
//
// One request per cycle enters while nothing stalls the pipe; each result passes stage
// registers 1 to 4 and the output register. A request whose rs1 is the destination of
// a load still in the pipe waits in stage 1 until that load writes the register file,
// once through the load path (index reduction, data memory read, load alignment).
// Reset clears the register file valid bits and all pipeline valids; data memory
// is not cleared. A stalled result holds in the output register while the stages
// behind it fill up before the request side is held off.
module rv32i_itype_execute_core import rvi_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input logic       clk,
  input logic       rst_n,
  rvi_in_if.sink    in_req,
  rvi_out_if.source out_rsp
);

  localparam int AW = $clog2(MEM_WORDS);

  // Stage 1 registers
  logic               s1_v_r;
  logic [ACT_W-1:0]   s1_act_r;
  logic [REG_W-1:0]   s1_rd_r;
  logic [REG_W-1:0]   s1_rs1_r;
  logic [IMM_W-1:0]   s1_imm_r;
  logic [XLEN-1:0]    s1_pc_r;
  logic [XLEN-1:0]    s1_pval_r;
  logic [PWORD_W-1:0] s1_pword_r;
  logic [XLEN-1:0]    rf_a_r;

  // Later stages
  logic    s2_v_r, s3_v_r, s4_v_r;
  ex_ctl_t s2_r, s3_r, s4_r;

  // Output register
  logic             out_valid_r;
  logic             out_we_r;
  logic [REG_W-1:0] out_reg_r;
  logic [XLEN-1:0]  out_val_r;
  logic             out_jump_r;
  logic [XLEN-1:0]  out_npc_r;

  // Storage
  logic [XLEN-1:0] rf_mem [32];
  logic [31:0]     rf_vld_r;
  logic [XLEN-1:0] dmem [MEM_WORDS];
  logic [XLEN-1:0] dm_lo_r;
  logic [XLEN-1:0] dm_hi_r;

  // Pipeline control
  logic accept;
  logic s1_adv, s2_adv, s3_adv, s4_adv;
  logic ld_haz;

  // Stage 1 datapath
  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] imm_sx;
  logic [4:0]      shamt;
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] alu_val;
  logic            s2_hit, s3_hit, s4_hit;
  logic            s1_is_pmem;
  logic [29:0]     s1_x;
  ex_ctl_t         s1_ctl;

  // Memory index and load alignment
  red_adv_t        red_adv;
  logic [AW-1:0]   dm_idx;
  logic [AW-1:0]   dm_idx2;
  logic [63:0]     dm_pair;
  logic [XLEN-1:0] ld_word;
  logic [XLEN-1:0] s4_val;

  // Register file write port
  logic             rf_we;
  logic [REG_W-1:0] rf_waddr;
  logic [XLEN-1:0]  rf_wdata;

  // Advance from the output back to the request side
  assign s4_adv = s4_v_r && (!out_valid_r || out_rsp.ready);
  assign s3_adv = s3_v_r && (!s4_v_r || s4_adv);
  assign s2_adv = s2_v_r && (!s3_v_r || s3_adv);
  assign s1_adv = s1_v_r && !ld_haz && (!s2_v_r || s2_adv);
  assign in_req.ready = !s1_v_r || s1_adv;
  assign accept = in_req.valid && in_req.ready;

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        s3_v_r <= 1'b1;
      end else if (s3_adv) begin
        s3_v_r <= 1'b0;
      end
      if (s3_adv) begin
        s4_v_r <= 1'b1;
      end else if (s4_adv) begin
        s4_v_r <= 1'b0;
      end
      if (s4_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r   <= in_req.action;
      s1_rd_r    <= in_req.dest_reg;
      s1_rs1_r   <= in_req.src_reg;
      s1_imm_r   <= in_req.immediate_bits;
      s1_pc_r    <= in_req.current_pc;
      s1_pval_r  <= in_req.preload_value;
      s1_pword_r <= in_req.preload_word;
    end
  end

  // Register file write from the last stage
  assign rf_we    = s4_adv && s4_r.wen;
  assign rf_waddr = s4_r.rd;
  assign rf_wdata = s4_val;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  // Read rs1 on accept, write-first; refresh it when a write lands while waiting
  always_ff @(posedge clk) begin
    if (accept) begin
      if (rf_we && (rf_waddr == in_req.src_reg)) begin
        rf_a_r <= rf_wdata;
      end else if (rf_vld_r[in_req.src_reg]) begin
        rf_a_r <= rf_mem[in_req.src_reg];
      end else begin
        rf_a_r <= '0;
      end
    end else if (rf_we && s1_v_r && (rf_waddr == s1_rs1_r)) begin
      rf_a_r <= rf_wdata;
    end
  end

  // Forward the newest pending result; hold on a pending load
  assign s2_hit = s2_v_r && s2_r.wen && (s2_r.rd == s1_rs1_r);
  assign s3_hit = s3_v_r && s3_r.wen && (s3_r.rd == s1_rs1_r);
  assign s4_hit = s4_v_r && s4_r.wen && (s4_r.rd == s1_rs1_r);

  always_comb begin
    op_a   = rf_a_r;
    ld_haz = 1'b0;
    if (s2_hit) begin
      op_a   = s2_r.val;
      ld_haz = s2_r.is_load;
    end else if (s3_hit) begin
      op_a   = s3_r.val;
      ld_haz = s3_r.is_load;
    end else if (s4_hit) begin
      op_a   = s4_r.val;
      ld_haz = s4_r.is_load;
    end
  end

  // Stage 1 arithmetic
  assign imm_sx = {{(XLEN-IMM_W){s1_imm_r[IMM_W-1]}}, s1_imm_r};
  assign shamt  = s1_imm_r[4:0];
  assign sum    = op_a + imm_sx;

  always_comb begin
    case (s1_act_r)
      ACT_ADDI:    alu_val = sum;
      ACT_SLLI:    alu_val = op_a << shamt;
      ACT_SLTI:    alu_val = {31'd0, $signed(op_a) < $signed(imm_sx)};
      ACT_SLTIU:   alu_val = {31'd0, op_a < imm_sx};
      ACT_XORI:    alu_val = op_a ^ imm_sx;
      ACT_ORI:     alu_val = op_a | imm_sx;
      ACT_ANDI:    alu_val = op_a & imm_sx;
      ACT_SRLI:    alu_val = op_a >> shamt;
      ACT_SRAI:    alu_val = XLEN'($signed(op_a) >>> shamt);
      ACT_JALR:    alu_val = s1_pc_r + 32'd4;
      ACT_PRE_REG: alu_val = s1_pval_r;
      ACT_PRE_MEM: alu_val = s1_pval_r;
      default:     alu_val = '0;
    endcase
  end

  assign s1_is_pmem = (s1_act_r == ACT_PRE_MEM);
  assign s1_x       = s1_is_pmem ? 30'(s1_pword_r) : sum[31:2];

  always_comb begin
    s1_ctl         = '0;
    s1_ctl.act     = s1_act_r;
    s1_ctl.rd      = s1_rd_r;
    s1_ctl.wen     = (s1_act_r <= ACT_PRE_REG) && (s1_rd_r != '0);
    s1_ctl.is_load = (s1_act_r <= ACT_LHU);
    s1_ctl.is_pmem = s1_is_pmem;
    s1_ctl.off     = sum[1:0];
    s1_ctl.val     = alu_val;
    s1_ctl.jump    = (s1_act_r == ACT_JALR);
    s1_ctl.npc     = s1_ctl.jump ? {sum[31:1], 1'b0} : s1_pc_r + 32'd4;
  end

  // Advance the control word
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_r <= s1_ctl;
    end
    if (s2_adv) begin
      s3_r <= s2_r;
    end
    if (s3_adv) begin
      s4_r <= s3_r;
    end
  end

  // Reduce the word address to a memory index
  assign red_adv.ld_s2 = s1_adv;
  assign red_adv.ld_s3 = s2_adv;

  rvi_idx_red #(
    .MEM_WORDS (MEM_WORDS)
  ) u_idx_red (
    .clk  (clk),
    .adv  (red_adv),
    .x_i  (s1_x),
    .w_o  (dm_idx),
    .w2_o (dm_idx2)
  );

  // Data memory: preload write, two-word read for loads
  always_ff @(posedge clk) begin
    if (s3_adv) begin
      if (s3_r.is_pmem) begin
        dmem[dm_idx] <= s3_r.val;
      end
      dm_lo_r <= dmem[dm_idx];
      dm_hi_r <= dmem[dm_idx2];
    end
  end

  // Align and extend the loaded bytes
  assign dm_pair = {dm_hi_r, dm_lo_r};

  always_comb begin
    case (s4_r.off)
      2'd0:    ld_word = dm_pair[31:0];
      2'd1:    ld_word = dm_pair[39:8];
      2'd2:    ld_word = dm_pair[47:16];
      2'd3:    ld_word = dm_pair[55:24];
      default: ld_word = dm_pair[31:0];
    endcase
  end

  always_comb begin
    case (s4_r.act)
      ACT_LB:  s4_val = {{24{ld_word[7]}}, ld_word[7:0]};
      ACT_LH:  s4_val = {{16{ld_word[15]}}, ld_word[15:0]};
      ACT_LW:  s4_val = ld_word;
      ACT_LBU: s4_val = {24'd0, ld_word[7:0]};
      ACT_LHU: s4_val = {16'd0, ld_word[15:0]};
      default: s4_val = s4_r.val;
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (s4_adv) begin
      out_we_r   <= s4_r.wen;
      out_reg_r  <= s4_r.wen ? s4_r.rd : '0;
      out_val_r  <= s4_r.wen ? s4_val : '0;
      out_jump_r <= s4_r.jump;
      out_npc_r  <= s4_r.npc;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.write_enable  = out_we_r;
  assign out_rsp.written_reg   = out_reg_r;
  assign out_rsp.written_value = out_val_r;
  assign out_rsp.jump_taken    = out_jump_r;
  assign out_rsp.next_pc       = out_npc_r;

  // Register zero is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_waddr != '0))
    else $error("register file write to x0");

  // Memory index stays inside the memory
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> ((dm_idx <= AW'(MEM_WORDS - 1)) && (dm_idx2 <= AW'(MEM_WORDS - 1))))
    else $error("data memory index out of range");

  // A jump target is halfword aligned
  a_jump_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_jump_r) |-> (out_npc_r[0] == 1'b0))
    else $error("jump target has bit 0 set");

  // A request leaving stage 1 never uses a load result still in flight
  a_no_load_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> !((s2_hit && s2_r.is_load) ||
                 (!s2_hit && s3_hit && s3_r.is_load) ||
                 (!s2_hit && !s3_hit && s4_hit && s4_r.is_load)))
    else $error("stage 1 advanced past a pending load");

endmodule

// ===== hdl/rvi_idx_red.sv =====
`timescale 1ns / 1ps
// Two-stage reduction of a word address modulo the data memory depth.
module rvi_idx_red import rvi_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic                              clk,
  input  red_adv_t                          adv,
  input  logic [29:0]                       x_i,
  output logic [$clog2(MEM_WORDS)-1:0]      w_o,
  output logic [$clog2(MEM_WORDS)-1:0]      w2_o
);

  localparam int          AW    = $clog2(MEM_WORDS);
  localparam logic [29:0] RECIP = 30'((64'd1 << 30) / MEM_WORDS);
  localparam logic [AW:0] MODW  = (AW+1)'(MEM_WORDS);
  localparam logic [AW-1:0] LASTW = AW'(MEM_WORDS - 1);

  logic [29:0] x2_r;
  logic [29:0] x3_r;
  logic [29:0] q_r;
  logic [59:0] prod;
  logic [AW:0] qm;
  logic [AW:0] rem;

  // Capture the word address as the request enters stage 2
  always_ff @(posedge clk) begin
    if (adv.ld_s2) begin
      x2_r <= x_i;
    end
  end

  // Estimate the quotient; it is exact or one low
  assign prod = {30'd0, x2_r} * {30'd0, RECIP};

  always_ff @(posedge clk) begin
    if (adv.ld_s3) begin
      q_r  <= prod[59:30];
      x3_r <= x2_r;
    end
  end

  // Remainder lies below twice the depth: one compare and subtract fixes it
  assign qm  = q_r[AW:0] * MODW;
  assign rem = x3_r[AW:0] - qm;

  always_comb begin
    if (rem >= MODW) begin
      w_o = AW'(rem - MODW);
    end else begin
      w_o = rem[AW-1:0];
    end
  end

  // Second word of a misaligned access wraps at the end of memory
  assign w2_o = (w_o == LASTW) ? '0 : AW'(w_o + 1'b1);

endmodule

// ===== tb/rv32i_itype_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the execute core: shadow state, result prediction and comparison.
module rv32i_itype_result_checker import rvi_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic clk,
  input  logic rst_n,
  rvi_in_if    req_bus,
  rvi_out_if   rsp_bus,
  output int   err_total,
  output int   pending_total,
  output int   req_total,
  output int   rsp_total,
  output int   load_total,
  output int   jump_total
);

  typedef struct packed {
    logic             wen;
    logic [REG_W-1:0] rd;
    logic [XLEN-1:0]  value;
    logic             jump;
    logic [XLEN-1:0]  npc;
  } exec_result_t;

  logic [XLEN-1:0] gpr_shadow [32];
  logic [XLEN-1:0] dmem_shadow [MEM_WORDS];
  exec_result_t    pending_results [$];
  int errs;
  int outstanding;
  int reqs;
  int rsps;
  int loads;
  int jumps;

  assign err_total     = errs;
  assign pending_total = outstanding;
  assign req_total     = reqs;
  assign rsp_total     = rsps;
  assign load_total    = loads;
  assign jump_total    = jumps;

  // Register file comes out of reset all zero
  initial begin
    for (int i = 0; i < 32; i++) gpr_shadow[i] = '0;
    errs        = 0;
    outstanding = 0;
    reqs        = 0;
    rsps        = 0;
    loads       = 0;
    jumps       = 0;
  end

  // Four little-endian bytes starting at addr; the second word wraps around memory
  function automatic logic [XLEN-1:0] fetch_bytes(input logic [XLEN-1:0] addr);
    int unsigned       lo_idx;
    int unsigned       hi_idx;
    logic [2*XLEN-1:0] pair;
    lo_idx = (addr >> 2) % MEM_WORDS;
    hi_idx = (lo_idx + 1) % MEM_WORDS;
    pair   = {dmem_shadow[hi_idx], dmem_shadow[lo_idx]};
    return XLEN'(pair >> (8 * addr[1:0]));
  endfunction

  // Execute one request against the shadow state and return its result
  function automatic exec_result_t execute_itype(
    input logic [ACT_W-1:0]   act,
    input logic [REG_W-1:0]   rd,
    input logic [REG_W-1:0]   rs1,
    input logic [IMM_W-1:0]   imm_raw,
    input logic [XLEN-1:0]    pc,
    input logic [XLEN-1:0]    pval,
    input logic [PWORD_W-1:0] pword
  );
    exec_result_t    res;
    logic [XLEN-1:0] src;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] val;
    logic [4:0]      shamt;
    logic            writes;
    src    = (rs1 == '0) ? '0 : gpr_shadow[rs1];
    imm    = {{(XLEN-IMM_W){imm_raw[IMM_W-1]}}, imm_raw};
    shamt  = imm_raw[4:0];
    val    = '0;
    writes = 1'b1;
    res    = '0;
    res.npc = pc + 32'd4;
    case (act)
      ACT_LB: begin
        val = fetch_bytes(src + imm);
        val = {{24{val[7]}}, val[7:0]};
      end
      ACT_LH: begin
        val = fetch_bytes(src + imm);
        val = {{16{val[15]}}, val[15:0]};
      end
      ACT_LW:    val = fetch_bytes(src + imm);
      ACT_LBU:   val = fetch_bytes(src + imm) & 32'h0000_00FF;
      ACT_LHU:   val = fetch_bytes(src + imm) & 32'h0000_FFFF;
      ACT_ADDI:  val = src + imm;
      ACT_SLLI:  val = src << shamt;
      ACT_SLTI:  val = ($signed(src) < $signed(imm)) ? 32'd1 : 32'd0;
      ACT_SLTIU: val = (src < imm) ? 32'd1 : 32'd0;
      ACT_XORI:  val = src ^ imm;
      ACT_ORI:   val = src | imm;
      ACT_ANDI:  val = src & imm;
      ACT_SRLI:  val = src >> shamt;
      ACT_SRAI:  val = $signed(src) >>> shamt;
      ACT_JALR: begin
        // rs1 was read above, so rd == rs1 links without disturbing the target
        val      = pc + 32'd4;
        res.jump = 1'b1;
        res.npc  = (src + imm) & 32'hFFFF_FFFE;
      end
      ACT_PRE_REG: val = pval;
      ACT_PRE_MEM: begin
        dmem_shadow[pword % MEM_WORDS] = pval;
        writes = 1'b0;
      end
      // Unused action codes leave all state alone
      default: writes = 1'b0;
    endcase
    // Drop writes to x0
    if (writes && rd != '0) begin
      gpr_shadow[rd] = val;
      res.wen   = 1'b1;
      res.rd    = rd;
      res.value = val;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [XLEN-1:0] want,
                             input logic [XLEN-1:0] got);
    if (want !== got) begin
      errs++;
      $error("%s: expected %h, got %h", field, want, got);
    end
  endtask

  // Predict on each accepted request, compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n) begin
      if (req_bus.valid && req_bus.ready) begin
        pending_results.push_back(execute_itype(req_bus.action, req_bus.dest_reg,
                                                req_bus.src_reg, req_bus.immediate_bits,
                                                req_bus.current_pc, req_bus.preload_value,
                                                req_bus.preload_word));
        reqs++;
        if (req_bus.action <= ACT_LHU) loads++;
        if (req_bus.action == ACT_JALR) jumps++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsps++;
        if (pending_results.size() == 0) begin
          errs++;
          $error("result arrived with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("write_enable", want.wen, rsp_bus.write_enable);
          check_field("written_reg", want.rd, rsp_bus.written_reg);
          check_field("written_value", want.value, rsp_bus.written_value);
          check_field("jump_taken", want.jump, rsp_bus.jump_taken);
          check_field("next_pc", want.npc, rsp_bus.next_pc);
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

// ===== tb/tb_rv32i_itype_execute_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the execute core: clock, reset, request stimulus, flow control and verdict.
module tb_rv32i_itype_execute_core;
  import rvi_pkg::*;

  localparam int MEM_WORDS        = 1024;
  localparam int NUM_BASE         = 4;      // x0..x3 hold addresses known to the stimulus
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int TIMEOUT_NS       = 4_000_000;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 5'd17;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 5'd31;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_hold = 1'b0;
  int   stim_phase = 0;
  int   tx_idle_pct = 7;
  int   rx_idle_pct = 52;

  int err_total;
  int pending_total;
  int req_total;
  int rsp_total;
  int load_total;
  int jump_total;

  // Stimulus-side knowledge: base register contents and which memory words hold data
  logic [XLEN-1:0] base_val [NUM_BASE];
  bit              mem_written [MEM_WORDS];
  int              written_list [$];

  rvi_in_if  req_if ();
  rvi_out_if rsp_if ();

  rv32i_itype_execute_core #(.MEM_WORDS(MEM_WORDS)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  rv32i_itype_result_checker #(.MEM_WORDS(MEM_WORDS)) result_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_bus       (req_if),
    .rsp_bus       (rsp_if),
    .err_total     (err_total),
    .pending_total (pending_total),
    .req_total     (req_total),
    .rsp_total     (rsp_total),
    .load_total    (load_total),
    .jump_total    (jump_total)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall at random, or hold off entirely while rx_hold is set
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long output stall once the sender runs without gaps, so the pipe backs up
  initial begin
    wait (stim_phase == 3);
    repeat (40) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Give up on a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [REG_W-1:0] rd,
                          input logic [REG_W-1:0] rs1, input logic [IMM_W-1:0] imm,
                          input logic [XLEN-1:0] pc, input logic [XLEN-1:0] pval,
                          input logic [PWORD_W-1:0] pword);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.action         <= act;
    req_if.dest_reg       <= rd;
    req_if.src_reg        <= rs1;
    req_if.immediate_bits <= imm;
    req_if.current_pc     <= pc;
    req_if.preload_value  <= pval;
    req_if.preload_word   <= pword;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Request whose preload fields and pc are don't-care noise
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [REG_W-1:0] rd,
                         input logic [REG_W-1:0] rs1, input logic [IMM_W-1:0] imm);
    send_req(act, rd, rs1, imm, $urandom, $urandom, PWORD_W'($urandom_range(MEM_WORDS-1)));
  endtask

  // Any destination except the base registers x1 to x3; x0 can also be picked
  function automatic logic [REG_W-1:0] pick_dest();
    int r;
    r = $urandom_range(31 - NUM_BASE + 1);
    return (r == 0) ? '0 : REG_W'(r + NUM_BASE - 1);
  endfunction

  // Mostly full-range words, sometimes small signed values near the immediates
  function automatic logic [XLEN-1:0] rand_word();
    logic [IMM_W-1:0] near;
    near = IMM_W'($urandom_range(4095));
    if ($urandom_range(3) == 0) return {{(XLEN-IMM_W){near[IMM_W-1]}}, near};
    return $urandom;
  endfunction

  task automatic preload_mem(input int word, input logic [XLEN-1:0] value);
    send_req(ACT_PRE_MEM, REG_W'($urandom_range(31)), REG_W'($urandom_range(31)),
             IMM_W'($urandom_range(4095)), $urandom, value, PWORD_W'(word));
    if (!mem_written[word]) begin
      mem_written[word] = 1'b1;
      written_list.push_back(word);
    end
  endtask

  task automatic preload_reg(input logic [REG_W-1:0] rd, input logic [XLEN-1:0] value);
    send_req(ACT_PRE_REG, rd, REG_W'($urandom_range(31)), IMM_W'($urandom_range(4095)),
             $urandom, value, PWORD_W'($urandom_range(MEM_WORDS-1)));
    if (rd != '0 && rd < NUM_BASE) base_val[rd] = value;
  endtask

  // A written word whose successor is also written, so a misaligned load stays defined
  function automatic int pick_load_word();
    int start;
    int w;
    start = $urandom_range(written_list.size() - 1);
    for (int k = 0; k < written_list.size(); k++) begin
      w = written_list[(start + k) % written_list.size()];
      if (mem_written[(w + 1) % MEM_WORDS]) return w;
    end
    return 0;
  endfunction

  // Load from word/offset through a base register; the immediate closes the gap
  task automatic issue_load(input logic [ACT_W-1:0] act, input int base, input int word,
                            input int off);
    logic [IMM_W-1:0] target;
    target = {PWORD_W'(word), 2'(off)};
    send_op(act, pick_dest(), REG_W'(base), target - base_val[base][IMM_W-1:0]);
  endtask

  task automatic random_item();
    int pick;
    int w;
    pick = $urandom_range(99);
    if (pick < 28) begin
      issue_load(ACT_W'($urandom_range(ACT_LHU, ACT_LB)), $urandom_range(NUM_BASE-1),
                 pick_load_word(), $urandom_range(3));
    end else if (pick < 34) begin
      // Half anywhere, half next to data already there to grow loadable pairs
      if ($urandom_range(1)) w = $urandom_range(MEM_WORDS-1);
      else w = (written_list[$urandom_range(written_list.size()-1)] + 1) % MEM_WORDS;
      preload_mem(w, rand_word());
    end else if (pick < 40) begin
      preload_reg(REG_W'($urandom_range(NUM_BASE-1, 1)), $urandom);
    end else if (pick < 48) begin
      preload_reg(pick_dest(), rand_word());
    end else if (pick < 55) begin
      send_op(ACT_JALR, pick_dest(), REG_W'($urandom_range(31)), IMM_W'($urandom_range(4095)));
    end else if (pick < 97) begin
      send_op(ACT_W'($urandom_range(ACT_SRAI, ACT_ADDI)), pick_dest(),
              REG_W'($urandom_range(31)), IMM_W'($urandom_range(4095)));
    end else begin
      send_op(ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)), REG_W'($urandom_range(31)),
              REG_W'($urandom_range(31)), IMM_W'($urandom_range(4095)));
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) random_item();
  endtask

  // Main sequence
  initial begin
    int drained;
    rst_n                 = 1'b0;
    req_if.valid          = 1'b0;
    req_if.action         = '0;
    req_if.dest_reg       = '0;
    req_if.src_reg        = '0;
    req_if.immediate_bits = '0;
    req_if.current_pc     = '0;
    req_if.preload_value  = '0;
    req_if.preload_word   = '0;
    for (int i = 0; i < NUM_BASE; i++) base_val[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: memory edges including the wrap from the last word to the first
    stim_phase = 1;
    preload_mem(MEM_WORDS - 1, 32'h8001_FF7F);
    preload_mem(0, 32'hFFFF_FFFF);
    preload_mem(1, 32'h0000_0000);
    preload_reg(5'd1, 32'hFFFF_FFFC);
    preload_reg(5'd2, 32'h8000_0000);
    preload_reg(5'd0, 32'hFFFF_FFFF);
    issue_load(ACT_LB, 1, MEM_WORDS - 1, 3);
    issue_load(ACT_LH, 1, MEM_WORDS - 1, 3);
    issue_load(ACT_LW, 2, MEM_WORDS - 1, 2);
    issue_load(ACT_LBU, 0, MEM_WORDS - 1, 1);
    issue_load(ACT_LHU, 2, MEM_WORDS - 1, 2);
    // Directed: every ALU operation, sign boundaries, ignored upper shift bits, x0 write
    send_op(ACT_ADDI, 5'd4, 5'd2, 12'h7FF);
    send_op(ACT_SLLI, 5'd5, 5'd4, 12'hFFF);
    send_op(ACT_SLTI, 5'd6, 5'd2, 12'h001);
    send_op(ACT_SLTIU, 5'd7, 5'd2, 12'h800);
    send_op(ACT_XORI, 5'd0, 5'd4, 12'hFFF);
    send_op(ACT_ORI, 5'd8, 5'd0, 12'h800);
    send_op(ACT_ANDI, 5'd9, 5'd4, 12'h7FF);
    send_op(ACT_SRLI, 5'd10, 5'd2, 12'h01F);
    send_op(ACT_SRAI, 5'd11, 5'd2, 12'h41F);
    // Directed: jalr linking into its own source, pc wrap, unused action codes
    send_req(ACT_JALR, 5'd4, 5'd4, 12'h801, 32'hFFFF_FFFC, 32'h0, 10'd0);
    send_req(ACT_UNUSED_LO, 5'd31, 5'd31, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    send_req(ACT_UNUSED_HI, 5'd3, 5'd3, 12'h000, 32'h0, 32'h0, 10'd0);

    run_random(240);

    // Sender sparse, receiver nearly always ready
    stim_phase  = 2;
    tx_idle_pct = 52;
    rx_idle_pct = 7;
    run_random(240);

    // No idling on either side, apart from the long output stall
    stim_phase  = 3;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(220);
    req_if.valid <= 1'b0;

    // Drain outstanding results, then let the pipe settle
    for (drained = 0; drained < DRAIN_LIMIT && pending_total != 0; drained++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_total != 0) $error("%0d results never arrived", pending_total);

    $display("Ran %0d requests (%0d loads, %0d jalr) and compared %0d results,",
             req_total, load_total, jump_total, rsp_total);
    $display("under sparse-sender, sparse-receiver, back-to-back and long-stall traffic.");
    if (err_total == 0 && pending_total == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
